FILE: rtl/core/insertion_sort_engine_top_macros.svh
// Assertion helpers shared by the RTL files that carry checks.
`ifndef INSERTION_SORT_ENGINE_TOP_MACROS_SVH
`define INSERTION_SORT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ise_pkg.sv
package ise_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_COUNT_DEF   = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    value;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

FILE: rtl/core/ise_cell.sv
// One slot of the sorted chain. On insert, an occupied cell holding a value
// strictly greater than the new one moves up by one place; on shift, every
// cell takes its right neighbor's value so the smallest leaves at cell zero.
module ise_cell (
    input  logic                 aclk,
    input  ise_pkg::cell_ctrl_t  ctrl,
    input  logic                 occupied,
    input  logic                 left_gt,
    input  ise_pkg::data_t       left_value,
    input  ise_pkg::data_t       right_value,
    output logic                 gt,
    output ise_pkg::data_t       value
);

    ise_pkg::data_t value_reg;
    ise_pkg::data_t value_next;

    // An empty cell counts as greater than anything, so it receives data.
    assign gt    = !occupied || (value_reg > ctrl.value);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        unique case (ctrl.op)
            ise_pkg::CELL_INSERT: begin
                if (gt) begin
                    value_next = left_gt ? left_value : ctrl.value;
                end
            end
            ise_pkg::CELL_SHIFT: begin
                value_next = right_value;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/core/insertion_sort_engine_top.sv
// Insertion sort engine: a stable ascending sorter for sets of signed 32-bit
// integers, built as a chain of MAX_COUNT cells.
// Input channel (s_*): one value per request; s_tlast marks the final value
// of a set. While loading, one request is taken every cycle. Values beyond
// MAX_COUNT in one set are dropped, but a dropped last still ends the set.
// Output channel (m_*): after the last request the set leaves in ascending
// order, one result per cycle while the receiver is ready, with m_tlast on
// the greatest value. After the last request is accepted, the state register
// turns to draining and the first pop then loads the output register. The set
// drains by shifting out through cell zero. The input takes no request while
// the chain drains, and takes one again once the state register returns to
// loading, which it does as the final value moves into the output register.
// A stalled receiver holds the output register; the chain then waits.
// Reset (aresetn low, synchronous) empties the chain and the output
// register; cell contents are not cleared, since only occupied cells are read.
`include "insertion_sort_engine_top_macros.svh"

module insertion_sort_engine_top #(
    parameter int MAX_COUNT = ise_pkg::MAX_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tlast    // last_res
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    ise_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    ise_pkg::data_t      m_value_reg, m_value_next;
    logic                m_last_reg, m_last_next;

    ise_pkg::cell_ctrl_t ctrl;
    ise_pkg::data_t      cell_value [MAX_COUNT];
    logic [MAX_COUNT-1:0] cell_gt;

    logic accept;
    logic insert;
    logic pop;
    logic pop_final;

    // Requests are taken only while loading.
    assign s_tready = (state_reg == ise_pkg::ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    // A full chain silently drops the request.
    assign insert   = accept && (count_reg < CNT_W'(MAX_COUNT));
    // While draining, move the smallest value out whenever the output register is free.
    assign pop      = (state_reg == ise_pkg::ST_DRAIN) && (count_reg != '0)
                      && (!m_valid_reg || m_tready);
    // The pop that moves the greatest value out.
    assign pop_final = pop && (count_reg == CNT_W'(1));

    always_comb begin
        ctrl.value = ise_pkg::data_t'(s_tdata);
        if (insert) begin
            ctrl.op = ise_pkg::CELL_INSERT;
        end else if (pop) begin
            ctrl.op = ise_pkg::CELL_SHIFT;
        end else begin
            ctrl.op = ise_pkg::CELL_HOLD;
        end
    end

    // The cell chain. Cell zero sees no greater left neighbor, and the top
    // cell refills itself on a shift since it is no longer occupied then.
    for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
        ise_pkg::data_t left_value;
        ise_pkg::data_t right_value;
        logic           left_gt;

        if (i == 0) begin : g_first
            assign left_gt    = 1'b0;
            assign left_value = ctrl.value;
        end else begin : g_inner
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == MAX_COUNT - 1) begin : g_top
            assign right_value = cell_value[i];
        end else begin : g_below
            assign right_value = cell_value[i+1];
        end

        ise_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (count_reg > CNT_W'(i)),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_value (right_value),
            .gt          (cell_gt[i]),
            .value       (cell_value[i])
        );
    end

    // Control: load until a last request, then drain the chain.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ise_pkg::ST_LOAD: begin
                if (insert) begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (accept && s_tlast) begin
                    state_next = ise_pkg::ST_DRAIN;
                end
            end
            ise_pkg::ST_DRAIN: begin
                if (pop) begin
                    count_next   = count_reg - CNT_W'(1);
                    m_valid_next = 1'b1;
                    m_value_next = cell_value[0];
                    m_last_next  = (count_reg == CNT_W'(1));
                end
                if ((count_reg == '0) || (pop && (count_reg == CNT_W'(1)))) begin
                    state_next = ise_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = ise_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ise_pkg::ST_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tlast  = m_last_reg;

    `ISE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_COUNT), "count over capacity")
    `ISE_ASSERT_NEXT(a_last_drains, accept && s_tlast, state_reg == ise_pkg::ST_DRAIN, "no drain")
    `ISE_ASSERT_NEXT(a_insert_count, insert, count_reg == $past(count_reg) + CNT_W'(1), "bad count")
    `ISE_ASSERT_NEXT(a_pop_head, pop, m_tvalid && (m_tdata == $past(cell_value[0])), "bad head")
    `ISE_ASSERT_NEXT(a_pop_last, pop_final, m_tlast && (count_reg == '0), "tlast missing")

endmodule
